>>> rtl/rtf_token_scanner_defines.svh
// Assertion macros shared by the RTF token scanner RTL.
`ifndef RTF_TOKEN_SCANNER_DEFINES_SVH
`define RTF_TOKEN_SCANNER_DEFINES_SVH
`ifndef SYNTHESIS
// cond must hold at every clock outside reset
`define RTF_ASSERT(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
    else $error("rtf_token_scanner: assertion failed");
// same-cycle implication
`define RTF_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rtf_token_scanner: implication failed");
// next-cycle implication
`define RTF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rtf_token_scanner: next-cycle implication failed");
`else
`define RTF_ASSERT(lbl, clk, rstn, cond)
`define RTF_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define RTF_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

>>> rtl/rtf_pkg.sv
// Shared types, constants and helpers for the RTF token scanner.
package rtf_pkg;

  localparam int NAME_LIMIT_DEF = 32;
  localparam int BYTE_W         = 8;
  localparam int PARAM_W        = 32;

  // token kinds
  localparam logic [2:0] KIND_OPEN  = 3'd0;
  localparam logic [2:0] KIND_CLOSE = 3'd1;
  localparam logic [2:0] KIND_WORD  = 3'd2;
  localparam logic [2:0] KIND_TEXT  = 3'd3;
  localparam logic [2:0] KIND_BIN   = 3'd4;

  // characters with a meaning to the scanner
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_I      = 8'h69;
  localparam logic [7:0] CH_N      = 8'h6e;

  typedef struct packed {
    logic              func;
    logic [BYTE_W-1:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]                kind;
    logic [BYTE_W-1:0]         text_byte;
    logic                      text_valid;
    logic                      has_param;
    logic signed [PARAM_W-1:0] param_value;
    logic                      token_end;
  } out_item_t;

  // loose hex digit: any byte maps to a nibble
  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    hex_nibble = c[3:0] + (c[4] ? 4'd0 : 4'd9);
  endfunction

endpackage

>>> rtl/rtf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rtf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AW-1:0]         waddr_i,
  input  logic [WIDTH-1:0]      wdata_i,
  input  logic [AW-1:0]         raddr_i,
  output logic [WIDTH-1:0]      rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/rtf_out_reg.sv
// One-entry output register for result items, valid/stall on the far side.
module rtf_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  rtf_pkg::out_item_t item_i,
  output logic               room_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rtf_pkg::out_item_t out_item_o
);
  logic               valid_q, valid_d;
  rtf_pkg::out_item_t item_q, item_d;

  // free, or emptied at this edge
  assign room_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (push_i) begin
      valid_d = 1'b1;
      item_d  = item_i;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

>>> rtl/rtf_token_scanner.sv
// Top level of the streaming RTF tokenizer: sequencer, name RAM and output register.
//
// Takes one RTF byte (or an end-of-input mark) per input item and produces
// token results: group open/close, control words with optional signed
// decimal parameter, control symbols, \' hex escapes, plain text and \bin
// payload bytes. One item is worked at a time; in_stall_o is high from
// the accept until its last result has been written into the output
// register, which then waits on out_stall_i while the next item is taken.
// Each item is accepted, then worked in one or more handling passes. A byte
// that ends a control word first sends the buffered letters one at a time,
// then is handled again unless it is a space; a \bin that opens a payload
// sends no letters, and a delimiter other than a space is handled again as
// the first payload byte. End of input finishes any pending token, then
// closes the group. The letter-at-a-time flush is set by the single read port
// of the name RAM and the one-entry output register, which takes one result
// per cycle while out_stall_i is low. Name letters live in the RAM
// (NAME_LIMIT entries, registered read); a read is only ever issued in a
// later handling pass than the last write of that word, so no forwarding is
// needed. Entries are never cleared: only letters of the current word are
// read back.
module rtf_token_scanner #(
  parameter int NAME_LIMIT = rtf_pkg::NAME_LIMIT_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  rtf_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rtf_pkg::out_item_t out_item_o
);
`include "rtf_token_scanner_defines.svh"

  localparam int IDX_W = (NAME_LIMIT > 1) ? $clog2(NAME_LIMIT) : 1;
  localparam int LEN_W = $clog2(NAME_LIMIT + 1);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(NAME_LIMIT);

  // sequencer phase
  typedef enum logic [1:0] {
    PH_READY,   // waiting for an item
    PH_HANDLE,  // one handling pass per cycle
    PH_FLUSH,   // sending buffered name letters
    PH_CLOSE    // end of input: close group, then clear
  } phase_e;

  // tokenizer mode between bytes
  typedef enum logic [3:0] {
    M_IDLE, M_ESC, M_NAME, M_NEG, M_DIGITS, M_HEX1, M_HEX2, M_TEXT, M_BIN
  } mode_e;

  phase_e                    phase_q, phase_d;
  mode_e                     mode_q, mode_d;
  logic [rtf_pkg::BYTE_W-1:0] byte_q, byte_d;
  logic                      eoi_q, eoi_d;
  logic [LEN_W-1:0]          len_q, len_d;
  logic [LEN_W-1:0]          idx_q, idx_d;
  logic [31:0]               acc_q, acc_d;
  logic                      neg_q, neg_d;
  logic                      seen_q, seen_d;
  logic [31:0]               rem_q, rem_d;
  logic                      bin_q, bin_d;   // letters so far are a prefix of "bin"

  logic                      push;
  logic                      can_load;
  rtf_pkg::out_item_t        oitem;

  logic                      ram_we;
  logic [IDX_W-1:0]          ram_waddr;
  logic [7:0]                ram_rdata;

  // byte classes and arithmetic on the held byte
  logic        is_letter, is_digit, is_delim, is_space;
  logic [31:0] word_val, acc10, hex_acc;
  logic        bin_hit, flush_last;

  assign is_letter = ((byte_q >= 8'h61) && (byte_q <= 8'h7a)) ||
                     ((byte_q >= 8'h41) && (byte_q <= 8'h5a));
  assign is_digit  = (byte_q >= 8'h30) && (byte_q <= 8'h39);
  assign is_delim  = (byte_q == rtf_pkg::CH_BSLASH) || (byte_q == rtf_pkg::CH_LBRACE) ||
                     (byte_q == rtf_pkg::CH_RBRACE) || (byte_q == rtf_pkg::CH_LF) ||
                     (byte_q == rtf_pkg::CH_CR);
  assign is_space  = (byte_q == rtf_pkg::CH_SPACE);

  assign word_val  = neg_q ? (32'd0 - acc_q) : acc_q;
  // acc*10 + digit, wraps at 32 bits
  assign acc10     = (acc_q << 3) + (acc_q << 1) + {28'd0, byte_q[3:0]};
  assign hex_acc   = {acc_q[27:0], rtf_pkg::hex_nibble(byte_q)};
  // \bin with a positive count turns into a payload
  assign bin_hit   = (int'(len_q) == 3) && bin_q && (word_val != 32'd0) && !word_val[31];
  assign flush_last = ((idx_q + LEN_W'(1)) == len_q);

  always_comb begin
    phase_d   = phase_q;
    mode_d    = mode_q;
    byte_d    = byte_q;
    eoi_d     = eoi_q;
    len_d     = len_q;
    idx_d     = idx_q;
    acc_d     = acc_q;
    neg_d     = neg_q;
    seen_d    = seen_q;
    rem_d     = rem_q;
    bin_d     = bin_q;
    push      = 1'b0;
    oitem     = '0;
    ram_we    = 1'b0;
    ram_waddr = len_q[IDX_W-1:0];

    unique case (phase_q)
      PH_READY: begin
        if (in_valid_i) begin
          byte_d  = in_item_i.data_byte;
          eoi_d   = in_item_i.func;
          phase_d = PH_HANDLE;
        end
      end

      PH_HANDLE: begin
        if (eoi_q) begin
          // finish whatever token is pending
          case (mode_q)
            M_TEXT: begin
              oitem.kind      = rtf_pkg::KIND_TEXT;
              oitem.token_end = 1'b1;
              if (can_load) begin
                push    = 1'b1;
                phase_d = PH_CLOSE;
              end
            end
            M_HEX2: begin
              oitem.kind        = rtf_pkg::KIND_WORD;
              oitem.text_byte   = rtf_pkg::CH_QUOTE;
              oitem.text_valid  = 1'b1;
              oitem.has_param   = 1'b1;
              oitem.param_value = acc_q;
              oitem.token_end   = 1'b1;
              if (can_load) begin
                push    = 1'b1;
                phase_d = PH_CLOSE;
              end
            end
            M_NAME, M_DIGITS: begin
              if (bin_hit) begin
                // payload announced but no byte came
                oitem.kind        = rtf_pkg::KIND_BIN;
                oitem.has_param   = 1'b1;
                oitem.param_value = word_val;
                oitem.token_end   = 1'b1;
                if (can_load) begin
                  push    = 1'b1;
                  phase_d = PH_CLOSE;
                end
              end else begin
                idx_d   = '0;
                phase_d = PH_FLUSH;
              end
            end
            M_BIN: begin
              oitem.kind        = rtf_pkg::KIND_BIN;
              oitem.has_param   = 1'b1;
              oitem.param_value = acc_q;
              oitem.token_end   = 1'b1;
              if (can_load) begin
                push    = 1'b1;
                phase_d = PH_CLOSE;
              end
            end
            default: begin
              // lone backslash, bare \' or a word ending in a lone minus: dropped
              phase_d = PH_CLOSE;
            end
          endcase
        end else begin
          unique case (mode_q)
            M_IDLE: begin
              if ((byte_q == rtf_pkg::CH_LF) || (byte_q == rtf_pkg::CH_CR)) begin
                phase_d = PH_READY;
              end else if (byte_q == rtf_pkg::CH_LBRACE) begin
                oitem.kind      = rtf_pkg::KIND_OPEN;
                oitem.token_end = 1'b1;
                if (can_load) begin
                  push    = 1'b1;
                  phase_d = PH_READY;
                end
              end else if (byte_q == rtf_pkg::CH_RBRACE) begin
                oitem.kind      = rtf_pkg::KIND_CLOSE;
                oitem.token_end = 1'b1;
                if (can_load) begin
                  push    = 1'b1;
                  phase_d = PH_READY;
                end
              end else if (byte_q == rtf_pkg::CH_BSLASH) begin
                mode_d  = M_ESC;
                phase_d = PH_READY;
              end else begin
                oitem.kind       = rtf_pkg::KIND_TEXT;
                oitem.text_byte  = byte_q;
                oitem.text_valid = 1'b1;
                if (can_load) begin
                  push    = 1'b1;
                  mode_d  = M_TEXT;
                  phase_d = PH_READY;
                end
              end
            end

            M_TEXT: begin
              oitem.kind = rtf_pkg::KIND_TEXT;
              if (is_delim) begin
                // close the run, handle the byte again next cycle
                oitem.token_end = 1'b1;
                if (can_load) begin
                  push   = 1'b1;
                  mode_d = M_IDLE;
                end
              end else begin
                oitem.text_byte  = byte_q;
                oitem.text_valid = 1'b1;
                if (can_load) begin
                  push    = 1'b1;
                  phase_d = PH_READY;
                end
              end
            end

            M_ESC: begin
              if (is_letter) begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                len_d     = LEN_W'(1);
                acc_d     = '0;
                neg_d     = 1'b0;
                seen_d    = 1'b0;
                bin_d     = (byte_q == rtf_pkg::CH_B);
                mode_d    = M_NAME;
                phase_d   = PH_READY;
              end else if (byte_q == rtf_pkg::CH_QUOTE) begin
                acc_d   = '0;
                mode_d  = M_HEX1;
                phase_d = PH_READY;
              end else begin
                // control symbol
                oitem.kind       = rtf_pkg::KIND_WORD;
                oitem.text_byte  = byte_q;
                oitem.text_valid = 1'b1;
                oitem.token_end  = 1'b1;
                if (can_load) begin
                  push    = 1'b1;
                  mode_d  = M_IDLE;
                  phase_d = PH_READY;
                end
              end
            end

            M_HEX1: begin
              acc_d   = {28'd0, rtf_pkg::hex_nibble(byte_q)};
              mode_d  = M_HEX2;
              phase_d = PH_READY;
            end

            M_HEX2: begin
              oitem.kind        = rtf_pkg::KIND_WORD;
              oitem.text_byte   = rtf_pkg::CH_QUOTE;
              oitem.text_valid  = 1'b1;
              oitem.has_param   = 1'b1;
              oitem.param_value = hex_acc;
              oitem.token_end   = 1'b1;
              if (can_load) begin
                push    = 1'b1;
                acc_d   = hex_acc;
                mode_d  = M_IDLE;
                phase_d = PH_READY;
              end
            end

            M_NAME, M_NEG, M_DIGITS: begin
              if ((mode_q == M_NAME) && is_letter && (len_q < LEN_MAX)) begin
                ram_we  = 1'b1;
                len_d   = len_q + LEN_W'(1);
                if (int'(len_q) == 1) begin
                  bin_d = bin_q && (byte_q == rtf_pkg::CH_I);
                end else if (int'(len_q) == 2) begin
                  bin_d = bin_q && (byte_q == rtf_pkg::CH_N);
                end
                phase_d = PH_READY;
              end else if ((mode_q == M_NAME) && (byte_q == rtf_pkg::CH_MINUS)) begin
                neg_d   = 1'b1;
                mode_d  = M_NEG;
                phase_d = PH_READY;
              end else if (is_digit) begin
                acc_d   = (mode_q == M_NAME) ? {28'd0, byte_q[3:0]} : acc10;
                seen_d  = 1'b1;
                mode_d  = M_DIGITS;
                phase_d = PH_READY;
              end else if (bin_hit) begin
                // word end: start a payload; non-space delimiter is its first byte
                rem_d   = word_val;
                acc_d   = word_val;
                neg_d   = 1'b0;
                seen_d  = 1'b1;
                mode_d  = M_BIN;
                phase_d = is_space ? PH_READY : PH_HANDLE;
              end else begin
                // word end: send the buffered letters
                idx_d   = '0;
                phase_d = PH_FLUSH;
              end
            end

            M_BIN: begin
              oitem.kind        = rtf_pkg::KIND_BIN;
              oitem.text_byte   = byte_q;
              oitem.text_valid  = 1'b1;
              oitem.has_param   = 1'b1;
              oitem.param_value = acc_q;
              oitem.token_end   = (rem_q <= 32'd1);
              if (can_load) begin
                push    = 1'b1;
                phase_d = PH_READY;
                if (rem_q <= 32'd1) begin
                  rem_d  = '0;
                  mode_d = M_IDLE;
                end else begin
                  rem_d  = rem_q - 32'd1;
                end
              end
            end

            default: begin
              mode_d = M_IDLE;
            end
          endcase
        end
      end

      PH_FLUSH: begin
        // RAM data always matches idx_q: the read is issued on idx_d
        oitem.kind       = rtf_pkg::KIND_WORD;
        oitem.text_byte  = ram_rdata;
        oitem.text_valid = 1'b1;
        if (flush_last) begin
          oitem.has_param   = seen_q;
          oitem.param_value = word_val;
          oitem.token_end   = 1'b1;
        end
        if (can_load) begin
          push = 1'b1;
          if (flush_last) begin
            mode_d = M_IDLE;
            if (eoi_q) begin
              phase_d = PH_CLOSE;
            end else if (is_space) begin
              phase_d = PH_READY;
            end else begin
              phase_d = PH_HANDLE;
            end
          end else begin
            idx_d = idx_q + LEN_W'(1);
          end
        end
      end

      PH_CLOSE: begin
        oitem.kind      = rtf_pkg::KIND_CLOSE;
        oitem.token_end = 1'b1;
        if (can_load) begin
          push    = 1'b1;
          mode_d  = M_IDLE;
          len_d   = '0;
          acc_d   = '0;
          neg_d   = 1'b0;
          seen_d  = 1'b0;
          rem_d   = '0;
          bin_d   = 1'b0;
          phase_d = PH_READY;
        end
      end

      default: begin
        phase_d = PH_READY;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_READY;
      mode_q  <= M_IDLE;
      byte_q  <= '0;
      eoi_q   <= 1'b0;
      len_q   <= '0;
      idx_q   <= '0;
      acc_q   <= '0;
      neg_q   <= 1'b0;
      seen_q  <= 1'b0;
      rem_q   <= '0;
      bin_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      mode_q  <= mode_d;
      byte_q  <= byte_d;
      eoi_q   <= eoi_d;
      len_q   <= len_d;
      idx_q   <= idx_d;
      acc_q   <= acc_d;
      neg_q   <= neg_d;
      seen_q  <= seen_d;
      rem_q   <= rem_d;
      bin_q   <= bin_d;
    end
  end

  assign in_stall_o = (phase_q != PH_READY);

  rtf_ram #(
    .WIDTH (rtf_pkg::BYTE_W),
    .DEPTH (NAME_LIMIT)
  ) u_name_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (byte_q),
    .raddr_i (idx_d[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  rtf_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .item_i      (oitem),
    .room_o      (can_load),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // a result is never written over one that is still held
  `RTF_ASSERT_IMPL(a_push_room, clk_i, rst_ni, push, can_load)
  // an accepted item is always worked on in the next cycle
  `RTF_ASSERT_NEXT(a_accept_handle, clk_i, rst_ni, in_valid_i && !in_stall_o, phase_q == PH_HANDLE)
  // flush index stays inside the stored name
  `RTF_ASSERT_IMPL(a_flush_idx, clk_i, rst_ni, phase_q == PH_FLUSH, idx_q < len_q)
  // payload mode always has bytes left
  `RTF_ASSERT_IMPL(a_bin_rem, clk_i, rst_ni, mode_q == M_BIN, rem_q != 32'd0)
  // name never grows past the buffer
  `RTF_ASSERT(a_len_max, clk_i, rst_ni, len_q <= LEN_MAX)

endmodule
